// File: hw/rtl/ghi_pkg.sv
// Shared types and constants for the gyro heading integrator.
// Used by ghi_ctrl, ghi_dp and gyro_heading_integrator; depends on nothing.
package ghi_pkg;

	// heading is kept in units of 2^-20 degree, modulo 360 degrees
	localparam int unsigned HEAD_W = 29;
	localparam logic [HEAD_W-1:0] HEAD_MOD = 29'd377487360;

	// calibration
	localparam int unsigned CAL_SAMPLES = 64;
	localparam int unsigned CNT_W = 8;
	localparam int unsigned SUM_W = 24;
	localparam int unsigned INTERVAL_W = 16;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd100;

	// rate scaling: delta = dt * diff / RATE_DEN, rounded
	localparam int unsigned RATE_DEN = 8000;
	localparam int unsigned REM_W = $clog2(RATE_DEN);
	localparam int unsigned DEN_W = REM_W + 1;
	localparam int unsigned DIFF_W = 25;
	localparam int unsigned PROD_W = 32 + DIFF_W;

	// serial divider: DIV_STEP quotient bits per cycle
	localparam int unsigned DIV_W = 60;
	localparam int unsigned DIV_STEP = 4;
	localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEP;
	localparam int unsigned DIVC_W = $clog2(DIV_CYCLES);

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic cal_acc;
		logic bias_load;
		logic prep;
		logic mul;
		logic rnd;
		logic div_step;
		logic bias_set;
		logic head_upd;
		logic drift;
		logic rec_first;
		logic rec_step;
		logic out_load;
		logic out_cal;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cal_last;
	} status_t;

endpackage

// File: hw/rtl/gyro_heading_integrator.sv
// Top level of the gyro heading integrator: controller plus datapath.
// Depends on ghi_pkg, ghi_ctrl and ghi_dp.
//
//  channel  handshake            payload
//  input    in_valid / in_stall  raw_rate[15:0] s, now_us[31:0], now_ms[31:0]
//  output   out_valid/out_stall  heading[28:0], calibrated
//  config   cfg_we               cfg_wdata[15:0] (drift_interval_ms)
//
// Calibration words go from acceptance through the rate sum to the output
// register; the last one also goes through the serial divider for the bias.
// Every later word passes prepare, multiply, rounding, the 4-bit-per-cycle
// divide-and-wrap unit, integrate, drift and output.
// One word is in work at a time; in_stall is high from acceptance until the
// result enters the output register, which waits while out_stall is high.
// Reset clears only control and block state; drift_interval_ms returns to 100.
module gyro_heading_integrator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] raw_rate,
	input  logic [31:0]        now_us,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [28:0]        heading,
	output logic               calibrated,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	import ghi_pkg::*;

	cmd_t    cmd;
	status_t status;

	ghi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ghi_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.raw_rate   (raw_rate),
		.now_us     (now_us),
		.now_ms     (now_ms),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.heading    (heading),
		.calibrated (calibrated)
	);

`ifndef SYNTHESIS
	// a word in work blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in work");

	// heading stays within one turn
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading < HEAD_MOD)
		else $error("heading outside one turn");

	// once calibrated, never back
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && calibrated |=> !out_valid || calibrated)
		else $error("calibrated flag dropped");
`endif

endmodule

// File: hw/rtl/ghi_dp.sv
// Datapath of the gyro heading integrator: calibration sums, multiplier,
// serial divide-and-wrap unit, heading and drift registers. Depends on ghi_pkg.
module ghi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ghi_pkg::cmd_t       cmd,
	output ghi_pkg::status_t    status,
	input  logic signed [15:0]  raw_rate,
	input  logic [31:0]         now_us,
	input  logic [31:0]         now_ms,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	output logic [28:0]         heading,
	output logic                calibrated
);
	import ghi_pkg::*;

	// captured word and working payload
	logic signed [15:0]       raw_q;
	logic [31:0]              us_q;
	logic [31:0]              ms_q;
	logic [31:0]              dt_q;
	logic [DIFF_W-1:0]        mag_q;
	logic                     neg_q;
	logic [DEN_W-1:0]         den_q;
	logic [DIV_W-1:0]         dividend_q;
	logic [REM_W-1:0]         rem_q;
	logic [HEAD_W-1:0]        qm_q;
	logic [HEAD_W-1:0]        heading_q;
	logic                     calibrated_q;

	// block state
	logic [INTERVAL_W-1:0]    interval_q;
	logic [CNT_W-1:0]         sample_count_q;
	logic signed [SUM_W-1:0]  rate_sum_q;
	logic signed [SUM_W-1:0]  rate_bias_q;
	logic [HEAD_W-1:0]        heading_acc_q;
	logic [HEAD_W-1:0]        first_heading_q;
	logic signed [HEAD_W:0]   drift_step_q;
	logic [31:0]              last_time_us_q;
	logic [31:0]              last_drift_ms_q;

	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_mag;
	logic [SUM_W-1:0]         sum_mag;
	logic [PROD_W-1:0]        prod;
	logic [DIV_W-1:0]         div_d;
	logic [REM_W-1:0]         div_r;
	logic [HEAD_W-1:0]        div_q;
	logic [HEAD_W:0]          h_pos;
	logic [HEAD_W:0]          h_neg;
	logic [HEAD_W-1:0]        h_int;
	logic [31:0]              elapsed;
	logic                     drift_due;
	logic signed [HEAD_W+1:0] h_sum;
	logic [HEAD_W-1:0]        h_wrap;
	logic [HEAD_W-1:0]        h_next;

	assign status.cal_last = (sample_count_q >= CNT_W'(CAL_SAMPLES - 1));
	assign heading = heading_q;
	assign calibrated = calibrated_q;

	// bias-corrected rate and its magnitude
	assign diff = $signed({raw_q[15], raw_q, 8'd0}) - $signed({rate_bias_q[SUM_W-1], rate_bias_q});
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign sum_mag = rate_sum_q[SUM_W-1] ? SUM_W'(-rate_sum_q) : SUM_W'(rate_sum_q);
	assign prod = PROD_W'(dt_q) * PROD_W'(mag_q);

	// divide step: shift out quotient bits, keep quotient modulo 360 degrees
	always_comb begin
		logic [DEN_W-1:0]  t;
		logic [HEAD_W:0]   u;
		logic              qb;
		div_d = dividend_q;
		div_r = rem_q;
		div_q = qm_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {div_r, div_d[DIV_W-1]};
			div_d = {div_d[DIV_W-2:0], 1'b0};
			qb = (t >= den_q);
			if (qb) begin
				t = t - den_q;
			end
			div_r = t[REM_W-1:0];
			u = {div_q, qb};
			if (u >= {1'b0, HEAD_MOD}) begin
				u = u - {1'b0, HEAD_MOD};
			end
			div_q = u[HEAD_W-1:0];
		end
	end

	// integrate: subtract signed delta, wrap into one turn
	assign h_pos = {1'b0, heading_acc_q} - {1'b0, qm_q};
	assign h_neg = {1'b0, heading_acc_q} + {1'b0, qm_q};
	always_comb begin
		if (neg_q) begin
			h_int = (h_neg >= {1'b0, HEAD_MOD}) ? HEAD_W'(h_neg - {1'b0, HEAD_MOD})
				: h_neg[HEAD_W-1:0];
		end else begin
			h_int = h_pos[HEAD_W] ? HEAD_W'(h_pos + {1'b0, HEAD_MOD}) : h_pos[HEAD_W-1:0];
		end
	end

	// drift: add drift step once the interval has been exceeded
	assign elapsed = ms_q - last_drift_ms_q;
	assign drift_due = (elapsed > {16'd0, interval_q});
	assign h_sum = $signed({2'b00, heading_acc_q}) + $signed({drift_step_q[HEAD_W], drift_step_q});
	always_comb begin
		if (h_sum < 0) begin
			h_wrap = HEAD_W'(h_sum + $signed({2'b00, HEAD_MOD}));
		end else if (h_sum >= $signed({2'b00, HEAD_MOD})) begin
			h_wrap = HEAD_W'(h_sum - $signed({2'b00, HEAD_MOD}));
		end else begin
			h_wrap = h_sum[HEAD_W-1:0];
		end
	end
	assign h_next = drift_due ? h_wrap : heading_acc_q;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= raw_rate;
			us_q <= now_us;
			ms_q <= now_ms;
		end
		if (cmd.prep) begin
			dt_q <= us_q - last_time_us_q;
			mag_q <= diff_mag;
			neg_q <= diff[DIFF_W-1];
			den_q <= DEN_W'(RATE_DEN);
		end
		if (cmd.bias_load) begin
			neg_q <= rate_sum_q[SUM_W-1];
			den_q <= DEN_W'(CAL_SAMPLES);
			dividend_q <= DIV_W'({sum_mag, 8'd0});
			rem_q <= '0;
			qm_q <= '0;
		end
		if (cmd.mul) begin
			dividend_q <= DIV_W'(prod);
			rem_q <= '0;
			qm_q <= '0;
		end
		if (cmd.rnd) begin
			dividend_q <= dividend_q + DIV_W'(den_q >> 1);
		end
		if (cmd.div_step) begin
			dividend_q <= div_d;
			rem_q <= div_r;
			qm_q <= div_q;
		end
		if (cmd.out_load) begin
			heading_q <= heading_acc_q;
			calibrated_q <= cmd.out_cal;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			sample_count_q <= '0;
			rate_sum_q <= '0;
			rate_bias_q <= '0;
			heading_acc_q <= '0;
			first_heading_q <= '0;
			drift_step_q <= '0;
			last_time_us_q <= '0;
			last_drift_ms_q <= '0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_wdata;
			end
			if (cmd.cal_acc) begin
				if (sample_count_q == '0) begin
					last_time_us_q <= us_q;
				end
				rate_sum_q <= rate_sum_q + SUM_W'(raw_q);
				sample_count_q <= sample_count_q + 1'b1;
			end
			if (cmd.bias_set) begin
				rate_bias_q <= neg_q ? SUM_W'(-qm_q[SUM_W-1:0]) : $signed(qm_q[SUM_W-1:0]);
			end
			if (cmd.head_upd) begin
				heading_acc_q <= h_int;
				last_time_us_q <= us_q;
			end
			if (cmd.drift) begin
				heading_acc_q <= h_next;
				if (drift_due) begin
					last_drift_ms_q <= ms_q;
				end
				if (cmd.rec_first) begin
					first_heading_q <= h_next;
				end
				if (cmd.rec_step) begin
					drift_step_q <= $signed({1'b0, h_next} - {1'b0, first_heading_q});
					last_drift_ms_q <= ms_q;
				end
			end
		end
	end

endmodule

// File: hw/rtl/ghi_ctrl.sv
// Controller of the gyro heading integrator: sequences calibration, the
// multiply/divide steps and the output register. Depends on ghi_pkg.
module ghi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ghi_pkg::status_t  status,
	output ghi_pkg::cmd_t     cmd
);
	import ghi_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CAL,
		S_BLOAD,
		S_PREP,
		S_MUL,
		S_RND,
		S_DIV,
		S_BIAS,
		S_HEAD,
		S_DRIFT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		P_CAL,
		P_DRIFT1,
		P_DRIFT2,
		P_RUN
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [DIVC_W-1:0] div_cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	// decode commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_CAL:   cmd.cal_acc = 1'b1;
			S_BLOAD: cmd.bias_load = 1'b1;
			S_PREP:  cmd.prep = 1'b1;
			S_MUL:   cmd.mul = 1'b1;
			S_RND:   cmd.rnd = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_BIAS:  cmd.bias_set = 1'b1;
			S_HEAD:  cmd.head_upd = 1'b1;
			S_DRIFT: begin
				cmd.drift = 1'b1;
				cmd.rec_first = (phase_q == P_DRIFT1);
				cmd.rec_step = (phase_q == P_DRIFT2);
			end
			S_OUT: begin
				cmd.out_load = out_free;
				cmd.out_cal = (phase_q == P_RUN);
			end
			default: cmd = '0;
		endcase
	end

	// state, phase, divide counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_CAL;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (phase_q == P_CAL) ? S_CAL : S_PREP;
					end
				end
				S_CAL: begin
					state_q <= status.cal_last ? S_BLOAD : S_OUT;
				end
				S_BLOAD: state_q <= S_RND;
				S_PREP:  state_q <= S_MUL;
				S_MUL:   state_q <= S_RND;
				S_RND: begin
					div_cnt_q <= DIVC_W'(DIV_CYCLES - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= (phase_q == P_CAL) ? S_BIAS : S_HEAD;
					end
				end
				S_BIAS: begin
					phase_q <= P_DRIFT1;
					state_q <= S_OUT;
				end
				S_HEAD: state_q <= S_DRIFT;
				S_DRIFT: begin
					// advance through the two drift samples
					case (phase_q)
						P_DRIFT1: phase_q <= P_DRIFT2;
						P_DRIFT2: phase_q <= P_RUN;
						default:  phase_q <= phase_q;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
